>>> rtl/core/sbpg_pkg.sv
// package for the scrolled bitmap pixel generator: constants, types, palette table
package sbpg_pkg;

  localparam int unsigned VramAw     = 14;
  localparam int unsigned VramDepth  = 1 << VramAw;
  localparam int unsigned LineBytes  = 64;
  localparam int unsigned ScreenLines = 256;
  localparam int unsigned LineW      = 8;
  localparam int unsigned ColW       = 6;
  localparam int unsigned RgbW       = 24;
  localparam int unsigned SlotW      = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 8;

  localparam logic [LineW-1:0] NoScroll     = 8'o330;
  localparam logic [7:0]       ScrollReset  = 8'o330;
  localparam logic [RgbW-1:0]  RgbWhite     = 24'hFFFFFF;
  localparam logic [RgbW-1:0]  RgbBlack     = 24'h000000;
  localparam logic [SlotW-1:0] LastSlot     = 3'd7;

  localparam logic [CfgIdxW-1:0] CfgPalette = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgColor   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgScroll  = 2'd2;

  localparam logic OpWrite = 1'b0;
  localparam logic OpFetch = 1'b1;

  typedef struct packed {
    logic              we;
    logic [VramAw-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [VramAw-1:0] raddr;
  } vram_req_t;

  localparam logic [RgbW-1:0] Palette [16][4] = '{
    '{24'h000000, 24'h0000FF, 24'h00FF00, 24'hFF0000},
    '{24'h000000, 24'hFFFF00, 24'hFF00FF, 24'hFF0000},
    '{24'h000000, 24'h00FFFF, 24'h0000FF, 24'hFF00FF},
    '{24'h000000, 24'h00FF00, 24'h00FFFF, 24'hFFFF00},
    '{24'h000000, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF},
    '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF},
    '{24'h000000, 24'hC00000, 24'h8E0000, 24'hFF0000},
    '{24'h000000, 24'hC0FF00, 24'h8EFF00, 24'hFFFF00},
    '{24'h000000, 24'hC000FF, 24'h8E00FF, 24'hFF00FF},
    '{24'h000000, 24'h8EFF00, 24'h8E00FF, 24'h8E0000},
    '{24'h000000, 24'hC0FF00, 24'hC000FF, 24'hC00000},
    '{24'h000000, 24'h00FFFF, 24'hFFFF00, 24'hFF0000},
    '{24'h000000, 24'hFF0000, 24'h00FF00, 24'h00FFFF},
    '{24'h000000, 24'h00FFFF, 24'hFFFF00, 24'hFFFFFF},
    '{24'h000000, 24'hFFFF00, 24'h00FF00, 24'hFFFFFF},
    '{24'h000000, 24'h00FFFF, 24'h00FF00, 24'hFFFFFF}
  };

  function automatic logic [RgbW-1:0] pal_rgb(input logic [3:0] sel, input logic [1:0] idx);
    return Palette[sel][idx];
  endfunction

endpackage

>>> rtl/core/sbpg_vram.sv
// video ram with one write and one registered read port, cleared by a sweep after reset
module sbpg_vram (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbpg_pkg::vram_req_t        req_i,
  output logic [7:0]                 rdata_o,
  output logic                       clr_busy_o
);

  logic [7:0] mem [sbpg_pkg::VramDepth];
  logic [7:0] rdata_q;
  logic       clr_q, clr_d;
  logic [sbpg_pkg::VramAw-1:0] clr_addr_q, clr_addr_d;
  logic       we;
  logic [sbpg_pkg::VramAw-1:0] waddr;
  logic [7:0] wdata;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (&clr_addr_q) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  assign we    = clr_q | req_i.we;
  assign waddr = clr_q ? clr_addr_q : req_i.waddr;
  assign wdata = clr_q ? 8'h00 : req_i.wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_q;

endmodule

>>> rtl/core/scrolled_bitmap_pixel_generator_unit.sv
// top level of the scrolled bitmap pixel generator
//
// channels: s_axis carries requests (tuser = op, 0 write byte, 1 fetch byte);
// m_axis carries pixels, eight per fetch, tlast on the eighth; cfg writes
// palette select (0), color mode (1) and scroll (2), other indexes ignored.
// a write request stores one byte into the 16 KB video ram and gives no pixel.
// a fetch reads the byte at ((line + scroll - 0330) mod 256) * 64 + column.
// the first pixel of a fetch waits for the video ram read register and then the
// serializer byte register before it is offered, then one pixel per cycle while
// m_axis_tready is high.
// flow: the pixel serializer holds one fetched byte at a time; requests
// are taken every cycle while no fetched byte waits behind the serializer.
// reset: registers return to palette 0, mono, scroll 0330, and the video ram
// is swept to zero, during which s_axis_tready stays low.
// a stalled receiver holds the current pixel; once one fetched byte waits
// behind the serializer s_axis_tready drops until the serializer frees up.
module scrolled_bitmap_pixel_generator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // write_address, write_data, screen_line, byte_column
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // pixel_rgb, pixel_slot
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [sbpg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sbpg_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [3:0] palette_q;
  logic       color_q;
  logic [7:0] scroll_q;

  logic [sbpg_pkg::VramAw-1:0] write_address;
  logic [7:0]                  write_data;
  logic [sbpg_pkg::LineW-1:0]  screen_line;
  logic [sbpg_pkg::ColW-1:0]   byte_column;
  logic [sbpg_pkg::LineW-1:0]  mem_line;
  logic [sbpg_pkg::VramAw-1:0] fetch_addr;

  sbpg_pkg::vram_req_t vram_req;
  logic [7:0] rdata;
  logic       clr_busy;

  logic in_acc, wr_acc, fetch_acc;
  logic rv_q, rv_d;
  logic busy_q, busy_d;
  logic [sbpg_pkg::SlotW-1:0] cnt_q, cnt_d;
  logic [7:0] byte_q, byte_d;
  logic ser_load, out_fire, is_last;
  logic [sbpg_pkg::RgbW-1:0] pixel_rgb;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= '0;
      color_q   <= 1'b0;
      scroll_q  <= sbpg_pkg::ScrollReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sbpg_pkg::CfgPalette: palette_q <= cfg_data_i[3:0];
        sbpg_pkg::CfgColor:   color_q   <= cfg_data_i[0];
        sbpg_pkg::CfgScroll:  scroll_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request fields
  assign write_address = s_axis_tdata[13:0];
  assign write_data    = s_axis_tdata[21:14];
  assign screen_line   = s_axis_tdata[29:22];
  assign byte_column   = s_axis_tdata[35:30];

  assign mem_line   = screen_line + scroll_q - sbpg_pkg::NoScroll;
  assign fetch_addr = sbpg_pkg::VramAw'(32'(mem_line) * sbpg_pkg::LineBytes)
                    + sbpg_pkg::VramAw'(32'(byte_column) % sbpg_pkg::LineBytes);

  assign is_last  = (cnt_q == sbpg_pkg::LastSlot);
  assign out_fire = busy_q & m_axis_tready;
  assign ser_load = rv_q & (~busy_q | (out_fire & is_last));

  assign s_axis_tready = ~clr_busy & (~rv_q | ser_load);
  assign in_acc    = s_axis_tvalid & s_axis_tready;
  assign wr_acc    = in_acc & (s_axis_tuser == sbpg_pkg::OpWrite);
  assign fetch_acc = in_acc & (s_axis_tuser == sbpg_pkg::OpFetch);

  always_comb begin
    vram_req       = '0;
    vram_req.we    = wr_acc;
    vram_req.waddr = write_address;
    vram_req.wdata = write_data;
    vram_req.re    = fetch_acc;
    vram_req.raddr = fetch_addr;
  end

  sbpg_vram u_vram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (vram_req),
    .rdata_o    (rdata),
    .clr_busy_o (clr_busy)
  );

  always_comb begin
    rv_d   = rv_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    byte_d = byte_q;
    if (ser_load) begin
      rv_d = 1'b0;
    end
    if (fetch_acc) begin
      rv_d = 1'b1;
    end
    if (ser_load) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      byte_d = rdata;
    end else if (out_fire) begin
      cnt_d = cnt_q + 1'b1;
      if (is_last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q   <= 1'b0;
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      rv_q   <= rv_d;
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  always_comb begin
    if (color_q) begin
      pixel_rgb = sbpg_pkg::pal_rgb(palette_q, byte_q[{cnt_q[2:1], 1'b0} +: 2]);
    end else begin
      pixel_rgb = byte_q[cnt_q] ? sbpg_pkg::RgbWhite : sbpg_pkg::RgbBlack;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {5'b0, cnt_q, pixel_rgb};
  assign m_axis_tlast  = is_last;

endmodule
